// ===== src/hrr_pkg.sv =====
package hrr_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CURSOR_W     = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_W        = 9;
    localparam int LEN_W        = 11;
    localparam int IDX_W        = 10;

    // Last report byte offset that still carries payload (257 byte report).
    localparam logic [OFF_W-1:0] OFF_LAST_PAYLOAD = 9'd256;
    localparam logic [OFF_W-1:0] OFF_SATURATE     = 9'd511;

    localparam int LC_CONTINUE = 0;
    localparam int LC_MORE     = 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ID  = 2'd1;

    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_MORE     = 3'd1,
        ST_DONE     = 3'd2,
        ST_SHORT    = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_STRAY    = 3'd6,
        ST_READ     = 3'd7
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       report_byte;
        logic             end_of_report;
        logic [IDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] message_length;
        logic [7:0]       read_data;
    } out_t;

    // Result of one word as decided at acceptance; read data follows from the RAM.
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] len;
        logic             rd_sel;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    // Report size for an id (link control byte included), 0 when unknown.
    function automatic logic [8:0] lookup_size(input logic hs, input logic [7:0] id);
        logic [8:0] sz;
        sz = '0;
        if (hs) begin
            case (id)
                8'h0D:   sz = 9'h005;
                8'h0E:   sz = 9'h009;
                8'h1F:   sz = 9'h00D;
                8'h10:   sz = 9'h011;
                8'h11:   sz = 9'h019;
                8'h12:   sz = 9'h031;
                8'h13:   sz = 9'h05F;
                8'h14:   sz = 9'h0C1;
                8'h15:   sz = 9'h0FF;
                default: sz = '0;
            endcase
        end else begin
            case (id)
                8'h05:   sz = 9'h008;
                8'h06:   sz = 9'h00A;
                8'h07:   sz = 9'h00E;
                8'h08:   sz = 9'h014;
                8'h09:   sz = 9'h03F;
                default: sz = '0;
            endcase
        end
        return sz;
    endfunction

endpackage

// ===== src/hrr_ram.sv =====
module hrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hrr_ctrl.sv =====
module hrr_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  hrr_pkg::in_t                     in_word,
    input  logic                             cfg_we,
    input  logic [hrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                             cfg_wdata,
    output hrr_pkg::res_t                    res,
    output hrr_pkg::wr_t                     wr,
    output logic                             re,
    output logic [hrr_pkg::ADDR_W-1:0]       raddr
);

    localparam int SUM_W = hrr_pkg::CURSOR_W + 1;

    logic [hrr_pkg::CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [hrr_pkg::OFF_W-1:0]    offset_reg, offset_next;
    logic [7:0]                   id_reg, id_next;
    logic [1:0]                   flags_reg, flags_next;
    logic                         hs_reg, ign_reg;

    logic [hrr_pkg::OFF_W-1:0]    off, pay;
    logic [hrr_pkg::CURSOR_W-1:0] base;
    logic [SUM_W-1:0]             wsum, psum;
    logic                         report, overflow, cont, more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            offset_reg <= '0;
            id_reg     <= '0;
            flags_reg  <= '0;
            hs_reg     <= 1'b0;
            ign_reg    <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            offset_reg <= offset_next;
            id_reg     <= id_next;
            flags_reg  <= flags_next;
            if (cfg_we && cfg_index == hrr_pkg::CFG_HIGH_SPEED) begin
                hs_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == hrr_pkg::CFG_IGNORE_ID) begin
                ign_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        off      = offset_reg;
        pay      = off - 9'd1;
        cont     = flags_reg[hrr_pkg::LC_CONTINUE];
        more     = flags_reg[hrr_pkg::LC_MORE];
        base     = cont ? cursor_reg : '0;
        wsum     = SUM_W'(base) + SUM_W'(off) - SUM_W'(2);
        psum     = SUM_W'(cursor_reg) + SUM_W'(pay);
        overflow = psum > SUM_W'(hrr_pkg::BUFFER_BYTES);
        report   = accept && !in_word.kind;

        cursor_next = cursor_reg;
        offset_next = offset_reg;
        id_next     = id_reg;
        flags_next  = flags_reg;

        res.status = hrr_pkg::ST_BYTE;
        res.len    = '0;
        res.rd_sel = 1'b0;

        // Store payload bytes as they arrive; drop anything past the buffer.
        wr.we   = report && off >= 9'd2 && off <= hrr_pkg::OFF_LAST_PAYLOAD
                  && wsum < SUM_W'(hrr_pkg::BUFFER_BYTES);
        wr.addr = wsum[hrr_pkg::ADDR_W-1:0];
        wr.data = in_word.report_byte;

        re    = accept && in_word.kind;
        raddr = hrr_pkg::ADDR_W'(in_word.read_index);

        if (accept && in_word.kind) begin
            res.status = hrr_pkg::ST_READ;
            res.rd_sel = 32'(in_word.read_index) < 32'(hrr_pkg::BUFFER_BYTES);
        end else if (report) begin
            if (off == 9'd0) begin
                id_next = in_word.report_byte;
            end else if (off == 9'd1) begin
                flags_next = in_word.report_byte[1:0];
            end

            if (in_word.end_of_report) begin
                offset_next = '0;
                if (off < 9'd2) begin
                    res.status = hrr_pkg::ST_SHORT;
                end else if (off > hrr_pkg::OFF_LAST_PAYLOAD) begin
                    res.status = hrr_pkg::ST_MISMATCH;
                end else if (!ign_reg && hrr_pkg::lookup_size(hs_reg, id_reg) != off) begin
                    res.status = hrr_pkg::ST_MISMATCH;
                end else if (overflow) begin
                    res.status  = hrr_pkg::ST_OVERFLOW;
                    cursor_next = '0;
                end else if (cont && cursor_reg == '0) begin
                    res.status = hrr_pkg::ST_STRAY;
                end else begin
                    // A first report restarts the message at zero.
                    cursor_next = cont ? psum[hrr_pkg::CURSOR_W-1:0]
                                       : hrr_pkg::CURSOR_W'(pay);
                    if (more) begin
                        res.status = hrr_pkg::ST_MORE;
                    end else begin
                        res.status  = hrr_pkg::ST_DONE;
                        res.len     = hrr_pkg::LEN_W'(cursor_next);
                        cursor_next = '0;
                    end
                end
            end else if (off < hrr_pkg::OFF_SATURATE) begin
                offset_next = off + 9'd1;
            end
        end
    end

endmodule

// ===== src/hid_report_reassembler.sv =====
// HID output report reassembler. Each input word is either one report byte
// (report id, link control byte, then payload, with end_of_report on the last
// byte) or a read of the reassembled message buffer at read_index. Every word
// yields exactly one result word: status 0 for a byte taken mid-report, a
// check outcome at report end (message done carries message_length), or
// status 7 with read_data for a read. Payload bytes go straight into a
// single 1024 x 8 message RAM at the message cursor (or from zero for a
// first report); the cursor, byte offset, id and link flags live in
// registers updated as each word is taken. The block takes one word per
// clock while the result side keeps up; each result passes through the
// registered RAM read and then the output register. The RAM is written
// and read from separate words, so there is never a write and a read in the
// same cycle, and a read right after a write sees the new byte. The buffer
// needs no clearing pass after reset; reading a byte never written returns
// an arbitrary value. Configuration (register 0 high_speed, register 1
// ignore_report_id) is always ready and should be written while idle.
module hid_report_reassembler (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  hrr_pkg::in_t                  s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output hrr_pkg::out_t                 m_data,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_wdata
);

    logic                         accept;
    hrr_pkg::res_t                res;
    hrr_pkg::wr_t                 wr;
    logic                         re;
    logic [hrr_pkg::ADDR_W-1:0]   raddr;
    logic [7:0]                   rdata;

    // Stage 1: decision made, waiting on RAM read data.
    logic                         s1_valid_reg, s1_valid_next;
    hrr_pkg::res_t                s1_res_reg;
    logic                         s1_advance;

    // Stage 2: output register.
    logic                         out_valid_reg, out_valid_next;
    hrr_pkg::out_t                out_reg;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    hrr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_word   (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res       (res),
        .wr        (wr),
        .re        (re),
        .raddr     (raddr)
    );

    // Read data register holds while stage 1 waits, since reads issue only on accept.
    hrr_ram #(
        .WIDTH (8),
        .DEPTH (hrr_pkg::BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        s1_valid_next = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on accept / advance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= res;
        end
        if (s1_advance) begin
            out_reg.status         <= s1_res_reg.status;
            out_reg.message_length <= s1_res_reg.len;
            out_reg.read_data      <= s1_res_reg.rd_sel ? rdata : 8'd0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== bench/tb_hid_report_reassembler.sv =====
`timescale 1ns / 100ps

module tb_hid_report_reassembler;

    // Stop the run at this many clocks if it has not ended on its own.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORT  = 257;
    localparam int OFFSET_CAP  = 511;
    localparam int FS_ENTRIES  = 5;
    localparam int HS_ENTRIES  = 9;
    // Table entries this size and up only get a three byte report.
    localparam int unsigned SHORT_TABLE_SIZE = 'h20;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    hrr_pkg::in_t                  s_data;
    logic                          m_valid;
    logic                          m_ready;
    hrr_pkg::out_t                 m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [hrr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic                          cfg_wdata;

    // Shadow of the block: message buffer, report walk state and registers.
    logic [7:0]  message_image [hrr_pkg::BUFFER_BYTES];
    bit          written [hrr_pkg::BUFFER_BYTES];
    bit          any_written = 1'b0;
    int unsigned cursor = 0;
    int unsigned offset = 0;
    logic [7:0]  cur_id = 8'h00;
    logic [1:0]  lflags = 2'b00;
    bit          cfg_hs = 1'b0;
    bit          cfg_ignore = 1'b0;

    // Results still owed by the block, oldest first.
    hrr_pkg::out_t pending_results [$];
    hrr_pkg::out_t got_word;
    hrr_pkg::out_t want_word;
    int          results_seen = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int unsigned cycle_count = 0;

    // Idling control: calm turns idling off on both sides; a bump of
    // hold_requests asks the result side for one long hold-off.
    bit          calm = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;

    hid_report_reassembler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Output report size tables (link control byte included), entry k.
    function automatic void table_entry(input bit hs, input int k,
                                        output logic [7:0] id, output int unsigned sz);
        id = 8'h00;
        sz = 0;
        if (hs) begin
            case (k)
                0: begin id = 8'h0D; sz = 'h05; end
                1: begin id = 8'h0E; sz = 'h09; end
                2: begin id = 8'h1F; sz = 'h0D; end
                3: begin id = 8'h10; sz = 'h11; end
                4: begin id = 8'h11; sz = 'h19; end
                5: begin id = 8'h12; sz = 'h31; end
                6: begin id = 8'h13; sz = 'h5F; end
                7: begin id = 8'h14; sz = 'hC1; end
                8: begin id = 8'h15; sz = 'hFF; end
                default: begin id = 8'h00; sz = 0; end
            endcase
        end else begin
            case (k)
                0: begin id = 8'h05; sz = 'h08; end
                1: begin id = 8'h06; sz = 'h0A; end
                2: begin id = 8'h07; sz = 'h0E; end
                3: begin id = 8'h08; sz = 'h14; end
                4: begin id = 8'h09; sz = 'h3F; end
                default: begin id = 8'h00; sz = 0; end
            endcase
        end
    endfunction

    // Size the selected table gives for an id; 0 means the id is unknown.
    function automatic int unsigned expected_size(input bit hs, input logic [7:0] id);
        logic [7:0]  eid;
        int unsigned esz;
        for (int k = 0; k < (hs ? HS_ENTRIES : FS_ENTRIES); k++) begin
            table_entry(hs, k, eid, esz);
            if (eid == id) return esz;
        end
        return 0;
    endfunction

    // Advance the shadow by one accepted word and return the result it owes.
    function automatic hrr_pkg::out_t reassemble_word(input hrr_pkg::in_t w);
        hrr_pkg::out_t r;
        int unsigned off;
        int unsigned base;
        int unsigned addr;
        int unsigned total;
        int unsigned payload;
        r = '0;
        if (w.kind) begin
            r.status    = hrr_pkg::ST_READ;
            r.read_data = message_image[w.read_index];
        end else begin
            off = offset;
            if (off == 0) begin
                cur_id = w.report_byte;
            end else if (off == 1) begin
                lflags = w.report_byte[1:0];
            end else if (off < MAX_REPORT) begin
                // Payload lands at the cursor for a continuation, else from zero.
                base = lflags[hrr_pkg::LC_CONTINUE] ? cursor : 0;
                addr = base + off - 2;
                if (addr < hrr_pkg::BUFFER_BYTES) begin
                    message_image[addr] = w.report_byte;
                    written[addr]       = 1'b1;
                    any_written         = 1'b1;
                end
            end
            if (w.end_of_report) begin
                total = off + 1;
                if (total < 3) begin
                    r.status = hrr_pkg::ST_SHORT;
                end else if (total > MAX_REPORT ||
                             (!cfg_ignore && expected_size(cfg_hs, cur_id) != total - 1)) begin
                    r.status = hrr_pkg::ST_MISMATCH;
                end else begin
                    payload = total - 2;
                    // Overflow is judged on the cursor before any restart.
                    if (cursor + payload > hrr_pkg::BUFFER_BYTES) begin
                        cursor   = 0;
                        r.status = hrr_pkg::ST_OVERFLOW;
                    end else if (lflags[hrr_pkg::LC_CONTINUE] && cursor == 0) begin
                        r.status = hrr_pkg::ST_STRAY;
                    end else begin
                        if (!lflags[hrr_pkg::LC_CONTINUE]) cursor = 0;
                        cursor += payload;
                        if (lflags[hrr_pkg::LC_MORE]) begin
                            r.status = hrr_pkg::ST_MORE;
                        end else begin
                            r.status         = hrr_pkg::ST_DONE;
                            r.message_length = hrr_pkg::LEN_W'(cursor);
                            cursor           = 0;
                        end
                    end
                end
                offset = 0;
            end else if (off < OFFSET_CAP) begin
                offset = off + 1;
            end
        end
        return r;
    endfunction

    // Random link control byte with the continue and more flags forced.
    function automatic logic [7:0] link_byte(input bit more, input bit cont);
        logic [7:0] lc;
        lc = 8'($urandom_range(0, 255));
        lc[hrr_pkg::LC_MORE]     = more;
        lc[hrr_pkg::LC_CONTINUE] = cont;
        return lc;
    endfunction

    // Any buffer position that has been written; never an unwritten one.
    function automatic logic [hrr_pkg::IDX_W-1:0] pick_written_index();
        int unsigned idx;
        idx = $urandom_range(0, hrr_pkg::BUFFER_BYTES - 1);
        for (int n = 0; n < hrr_pkg::BUFFER_BYTES && !written[idx]; n++)
            idx = (idx + 1) % hrr_pkg::BUFFER_BYTES;
        return idx[hrr_pkg::IDX_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    endtask

    // Offer one word, hold it until taken, then log the result it owes.
    task automatic send_word(input hrr_pkg::in_t w);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(reassemble_word(w));
        words_sent++;
    endtask

    // One report of total bytes: id, link control, random payload.
    task automatic send_report(input logic [7:0] id, input logic [7:0] lc, input int total);
        hrr_pkg::in_t w;
        for (int i = 0; i < total; i++) begin
            w.kind          = 1'b0;
            w.report_byte   = (i == 0) ? id : (i == 1) ? lc : 8'($urandom_range(0, 255));
            w.end_of_report = (i == total - 1);
            w.read_index    = hrr_pkg::IDX_W'($urandom_range(0, 1023));
            send_word(w);
        end
    endtask

    task automatic send_read(input logic [hrr_pkg::IDX_W-1:0] idx);
        hrr_pkg::in_t w;
        w.kind          = 1'b1;
        w.report_byte   = 8'($urandom_range(0, 255));
        w.end_of_report = 1'($urandom_range(0, 1));
        w.read_index    = idx;
        send_word(w);
    endtask

    task automatic read_some(input int n);
        if (!any_written) return;
        repeat (n) send_read(pick_written_index());
    endtask

    // Drop valid, wait for every owed result, then allow the pipeline to settle.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write both registers back to back while the block is idle.
    task automatic set_mode(input bit hs, input bit ign);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_index <= hrr_pkg::CFG_HIGH_SPEED;
        cfg_wdata <= hs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_hs = hs;
        cfg_index <= hrr_pkg::CFG_IGNORE_ID;
        cfg_wdata <= ign;
        do @(posedge aclk); while (!cfg_ready);
        cfg_ignore = ign;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One well-formed message of one to four reports with random payload.
    task automatic send_message();
        int          parts;
        int          k;
        int          total;
        int unsigned sz;
        logic [7:0]  id;
        parts = $urandom_range(1, 4);
        for (int p = 0; p < parts; p++) begin
            if (cfg_ignore) begin
                id    = 8'($urandom_range(0, 255));
                total = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 64)
                                                    : $urandom_range(3, 24);
            end else begin
                // Keep to the smaller table entries.
                k = $urandom_range(0, cfg_hs ? 4 : 3);
                table_entry(cfg_hs, k, id, sz);
                total = sz + 1;
            end
            send_report(id, link_byte(p != parts - 1, p != 0), total);
        end
    endtask

    // Reports of one and two bytes, a good report read back, unknown ids.
    task automatic test_length_checks();
        send_report(8'h05, 8'h00, 1);
        send_report(8'h05, 8'h00, 2);
        send_report(8'h05, link_byte(1'b0, 1'b0), 9);
        send_read(10'd0);
        send_read(10'd6);
        send_report(8'hFF, 8'hFF, 5);
        send_report(8'h00, 8'h00, 3);
    endtask

    // Multi-report message, stray continuation, restart over a partial message.
    task automatic test_message_chain();
        send_report(8'h05, link_byte(1'b1, 1'b0), 9);
        send_report(8'h05, link_byte(1'b1, 1'b1), 9);
        send_report(8'h05, link_byte(1'b0, 1'b1), 9);
        read_some(3);
        send_report(8'h05, link_byte(1'b0, 1'b1), 9);
        send_report(8'h05, link_byte(1'b1, 1'b0), 9);
        send_report(8'h05, link_byte(1'b0, 1'b0), 9);
        read_some(2);
    endtask

    // Every entry of both tables (large ones as a short report), then one
    // report a byte short and an id of the other table.
    task automatic test_speed_tables();
        logic [7:0]  id;
        logic [7:0]  other;
        int unsigned sz;
        int unsigned osz;
        for (int s = 0; s < 2; s++) begin
            set_mode(s[0], 1'b0);
            for (int k = 0; k < (s[0] ? HS_ENTRIES : FS_ENTRIES); k++) begin
                table_entry(s[0], k, id, sz);
                if (sz < SHORT_TABLE_SIZE)
                    send_report(id, link_byte(1'b0, 1'b0), sz + 1);
                else
                    send_report(id, link_byte(1'b0, 1'b0), 3);
            end
            table_entry(s[0], 0, id, sz);
            table_entry(!s[0], 0, other, osz);
            send_report(id, link_byte(1'b0, 1'b0), sz);
            send_report(other, link_byte(1'b0, 1'b0), osz + 1);
            read_some(2);
        end
    endtask

    // Length from the end marker: bounds, a two report message, a stray continuation.
    task automatic test_ignore_id();
        set_mode(1'b0, 1'b1);
        send_report(8'h00, link_byte(1'b0, 1'b0), 3);
        send_report(8'h5A, link_byte(1'b0, 1'b0), MAX_REPORT + 1);
        send_report(8'h33, link_byte(1'b0, 1'b0), 2);
        send_report(8'h11, link_byte(1'b1, 1'b0), 7);
        send_report(8'h11, link_byte(1'b0, 1'b1), 5);
        send_report(8'h22, link_byte(1'b0, 1'b1), 4);
        send_read(10'd0);
        read_some(3);
    endtask

    // Hold the result side off while words keep coming, so the block stalls input.
    task automatic test_backpressure();
        hold_requests++;
        repeat (4) begin
            send_report(8'h05, link_byte(1'b0, 1'b0), 9);
            read_some(1);
        end
    endtask

    // Mostly well-formed messages, with reads and malformed reports mixed in.
    task automatic test_random_traffic(input int words);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < words) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_message();
            else if (pick < 75)
                read_some($urandom_range(1, 4));
            else
                send_report(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            $urandom_range(1, 20));
        end
    endtask

    // Result side: random ready bursts, plus the long hold when one is asked for.
    initial begin : result_sink
        int n;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = calm ? 1 : $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Compare each taken result word with the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            got_word = m_data;
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing owed, status", got_word.status, 0);
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.status !== want_word.status)
                    flag_mismatch("status", got_word.status, want_word.status);
                if (got_word.message_length !== want_word.message_length)
                    flag_mismatch("message_length", got_word.message_length,
                                  want_word.message_length);
                if (got_word.read_data !== want_word.read_data)
                    flag_mismatch("read_data", got_word.read_data, want_word.read_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     pending_results.size());
            $display("hid_report_reassembler regression: fail");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= hrr_pkg::CFG_HIGH_SPEED;
        cfg_wdata <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_length_checks();
        test_message_chain();
        test_speed_tables();
        test_ignore_id();
        test_backpressure();

        set_mode(1'b0, 1'b0);
        test_random_traffic(30);
        set_mode(1'b1, 1'b0);
        test_random_traffic(30);
        set_mode(1'b1, 1'b1);
        test_random_traffic(30);
        set_mode(1'b0, 1'b1);
        calm = 1'b1;
        test_random_traffic(40);

        // Drain, then leave room for any stray word the block might still emit.
        wait_for_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("hid_report_reassembler regression: pass");
        end else begin
            $display("hid_report_reassembler regression: fail");
        end
        $finish;
    end

endmodule
